// ===== rtl/color_keyed_rect_blit_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the color-keyed rectangle blitter
// Shared shorthand for the concurrent checks in the RTL modules.
// ----------------------------------------------------------------------------
`ifndef COLOR_KEYED_RECT_BLIT_CORE_MACROS_SVH
`define COLOR_KEYED_RECT_BLIT_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CKRB_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CKRB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ckrb_pkg.sv =====
// ----------------------------------------------------------------------------
// ckrb_pkg
// Types, register codes and constants shared by the blitter modules.
// ----------------------------------------------------------------------------
package ckrb_pkg;

  // Frame-buffer row pitch in bytes.
  localparam logic [15:0] SCREEN_WIDTH = 16'd320;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_DEST_START  = 3'd0,
    CFG_RECT_WIDTH  = 3'd1,
    CFG_RECT_HEIGHT = 3'd2,
    CFG_BLIT_MODE   = 3'd3,
    CFG_COLOR_ADD   = 3'd4
  } cfg_idx_e;

  // Reset values of the registers.
  localparam logic [15:0] DEST_START_RST  = 16'd0;
  localparam logic [8:0]  RECT_WIDTH_RST  = 9'd1;
  localparam logic [7:0]  RECT_HEIGHT_RST = 8'd1;
  localparam logic [1:0]  BLIT_MODE_RST   = 2'd0;
  localparam logic [7:0]  COLOR_ADD_RST   = 8'd0;

  typedef struct packed {
    logic [15:0] dest_start;
    logic [8:0]  rect_width;
    logic [7:0]  rect_height;
    logic [1:0]  blit_mode;
    logic [7:0]  color_add;
  } cfg_t;

  // Rectangle restart caused by a geometry register write.
  typedef struct packed {
    logic        valid;
    logic [15:0] start;
  } restart_t;

  // One pixel on its way from the input register to the result register.
  typedef struct packed {
    logic [7:0]  src;
    logic [15:0] addr;
    logic        last;
    logic        keyed;
    logic        add;
    logic [7:0]  color_add;
  } pix_job_t;

endpackage

// ===== rtl/color_keyed_rect_blit_core.sv =====
// ----------------------------------------------------------------------------
// color_keyed_rect_blit_core
// 8-bit-per-pixel rectangle blitter with zero color key and optional
// wrapping color add; turns a row-major pixel stream into frame-buffer writes.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Beat contents
//   -------  ---------  ---------------------  ---------------------------------
//   in       sink       in_valid_i/in_stall_o  src_pixel_i
//   out      source     out_valid_o/out_stall_i dest_address_o, pixel_out_o,
//                                              write_enable_o, last_pixel_o
//   cfg      sink       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// Each pixel beat passes through two registers, first the input register
// and then the result register.
// One beat is accepted every cycle unless held by an output stall; the rate
// is set by the single pass through the key/add logic between the registers.
// A stall on the output ripples back to in_stall_o in the same cycle, and the
// two registers hold up to two beats while the output is stalled.
// Reset is asynchronous and active low; it sets the registers to their
// defaults and clears the rectangle counters. cfg_ready_o is always high.
// ----------------------------------------------------------------------------
module color_keyed_rect_blit_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Pixel input
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [7:0]                        src_pixel_i,
  // Write output
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [15:0]                       dest_address_o,
  output logic [7:0]                        pixel_out_o,
  output logic                              write_enable_o,
  output logic                              last_pixel_o,
  // Configuration writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ckrb_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  logic [ckrb_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  ckrb_pkg::cfg_t     cfg;
  ckrb_pkg::restart_t restart;
  ckrb_pkg::pix_job_t job;
  logic [15:0]        addr;
  logic               last;
  logic               in_accept;

  // The counters step exactly when a pixel beat enters the input register.
  assign in_accept = in_valid_i & ~in_stall_o;

  ckrb_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg),
    .restart_o   (restart)
  );

  ckrb_addr_gen u_addr_gen (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .restart_i (restart),
    .advance_i (in_accept),
    .addr_o    (addr),
    .last_o    (last)
  );

  // Mode decode: any nonzero mode keys out zero, bit 1 enables the add,
  // so mode 3 behaves like mode 2.
  always_comb begin
    job.src       = src_pixel_i;
    job.addr      = addr;
    job.last      = last;
    job.keyed     = (cfg.blit_mode != 2'd0);
    job.add       = cfg.blit_mode[1];
    job.color_add = cfg.color_add;
  end

  ckrb_pixel_pipe u_pixel_pipe (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .job_i          (job),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .dest_address_o (dest_address_o),
    .pixel_out_o    (pixel_out_o),
    .write_enable_o (write_enable_o),
    .last_pixel_o   (last_pixel_o)
  );

endmodule

// ===== rtl/ckrb_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// ckrb_cfg_regs
// Configuration register file; flags geometry writes as rectangle restarts.
// ----------------------------------------------------------------------------
module ckrb_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ckrb_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  logic [ckrb_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output ckrb_pkg::cfg_t                    cfg_o,
  output ckrb_pkg::restart_t                restart_o
);

  ckrb_pkg::cfg_t cfg_q, cfg_d;
  logic           wr;

  assign cfg_ready_o = 1'b1;
  assign wr          = cfg_valid_i & cfg_ready_o;

  always_comb begin
    cfg_d             = cfg_q;
    restart_o.valid   = 1'b0;
    restart_o.start   = cfg_q.dest_start;
    if (wr) begin
      case (ckrb_pkg::cfg_idx_e'(cfg_index_i))
        ckrb_pkg::CFG_DEST_START: begin
          cfg_d.dest_start = cfg_data_i[15:0];
          restart_o.valid  = 1'b1;
          restart_o.start  = cfg_data_i[15:0];
        end
        ckrb_pkg::CFG_RECT_WIDTH: begin
          cfg_d.rect_width = cfg_data_i[8:0];
          restart_o.valid  = 1'b1;
        end
        ckrb_pkg::CFG_RECT_HEIGHT: begin
          cfg_d.rect_height = cfg_data_i[7:0];
          restart_o.valid   = 1'b1;
        end
        ckrb_pkg::CFG_BLIT_MODE: begin
          cfg_d.blit_mode = cfg_data_i[1:0];
        end
        ckrb_pkg::CFG_COLOR_ADD: begin
          cfg_d.color_add = cfg_data_i[7:0];
        end
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dest_start  <= ckrb_pkg::DEST_START_RST;
      cfg_q.rect_width  <= ckrb_pkg::RECT_WIDTH_RST;
      cfg_q.rect_height <= ckrb_pkg::RECT_HEIGHT_RST;
      cfg_q.blit_mode   <= ckrb_pkg::BLIT_MODE_RST;
      cfg_q.color_add   <= ckrb_pkg::COLOR_ADD_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/ckrb_addr_gen.sv =====
// ----------------------------------------------------------------------------
// ckrb_addr_gen
// Column/row counters and row base address of the rectangle walk.
// ----------------------------------------------------------------------------
`include "color_keyed_rect_blit_core_macros.svh"

module ckrb_addr_gen (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ckrb_pkg::cfg_t      cfg_i,
  input  ckrb_pkg::restart_t  restart_i,
  input  logic                advance_i,
  output logic [15:0]         addr_o,
  output logic                last_o
);

  logic [8:0]  col_q, col_d;
  logic [7:0]  row_q, row_d;
  logic [15:0] base_q, base_d;
  logic [8:0]  w_m1;
  logic [7:0]  h_m1;
  logic        end_row;

  // A zero width or height acts as one.
  assign w_m1    = (cfg_i.rect_width == 9'd0) ? 9'd0 : cfg_i.rect_width - 9'd1;
  assign h_m1    = (cfg_i.rect_height == 8'd0) ? 8'd0 : cfg_i.rect_height - 8'd1;
  assign end_row = (col_q >= w_m1);
  assign last_o  = end_row & (row_q >= h_m1);
  assign addr_o  = base_q + {7'd0, col_q};

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    base_d = base_q;
    if (restart_i.valid) begin
      col_d  = 9'd0;
      row_d  = 8'd0;
      base_d = restart_i.start;
    end else if (advance_i) begin
      if (last_o) begin
        col_d  = 9'd0;
        row_d  = 8'd0;
        base_d = cfg_i.dest_start;
      end else if (end_row) begin
        col_d  = 9'd0;
        row_d  = row_q + 8'd1;
        base_d = base_q + ckrb_pkg::SCREEN_WIDTH;
      end else begin
        col_d = col_q + 9'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= 9'd0;
      row_q  <= 8'd0;
      base_q <= ckrb_pkg::DEST_START_RST;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      base_q <= base_d;
    end
  end

  `CKRB_ASSERT_IMPL(a_col_in_row, clk_i, rst_ni, 1'b1, col_q <= w_m1, "column past row end")
  `CKRB_ASSERT_IMPL(a_row_in_rect, clk_i, rst_ni, 1'b1, row_q <= h_m1, "row past rect end")
  `CKRB_ASSERT_NEXT(a_last_wraps, clk_i, rst_ni, advance_i && last_o,
                    col_q == 9'd0 && row_q == 8'd0, "counts not cleared after last pixel")

endmodule

// ===== rtl/ckrb_pixel_pipe.sv =====
// ----------------------------------------------------------------------------
// ckrb_pixel_pipe
// Input register, color-key and color-add logic, and result register.
// ----------------------------------------------------------------------------
`include "color_keyed_rect_blit_core_macros.svh"

module ckrb_pixel_pipe (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ckrb_pkg::pix_job_t  job_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [15:0]         dest_address_o,
  output logic [7:0]          pixel_out_o,
  output logic                write_enable_o,
  output logic                last_pixel_o
);

  logic               s1_valid_q, s1_valid_d;
  logic               out_valid_q, out_valid_d;
  ckrb_pkg::pix_job_t job_q;
  logic               out_ready;
  logic               s1_ready;
  logic               in_accept;
  logic               we;
  logic [7:0]         sum;
  logic [7:0]         pix;
  logic [15:0]        addr_q;
  logic [7:0]         pix_q;
  logic               we_q;
  logic               last_q;

  assign out_ready  = ~out_valid_q | ~out_stall_i;
  assign s1_ready   = ~s1_valid_q | out_ready;
  assign in_stall_o = ~s1_ready;
  assign in_accept  = in_valid_i & s1_ready;

  // Zero is the key color whenever keying is on.
  assign we  = ~(job_q.keyed & (job_q.src == 8'd0));
  assign sum = job_q.src + job_q.color_add;
  assign pix = we ? (job_q.add ? sum : job_q.src) : 8'd0;

  always_comb begin
    s1_valid_d  = s1_valid_q;
    out_valid_d = out_valid_q;
    if (out_ready) begin
      out_valid_d = s1_valid_q;
    end
    if (s1_ready) begin
      s1_valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      job_q <= job_i;
    end
    if (out_ready && s1_valid_q) begin
      addr_q <= job_q.addr;
      pix_q  <= pix;
      we_q   <= we;
      last_q <= job_q.last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign dest_address_o = addr_q;
  assign pixel_out_o    = pix_q;
  assign write_enable_o = we_q;
  assign last_pixel_o   = last_q;

  `CKRB_ASSERT_IMPL(a_masked_zero, clk_i, rst_ni, out_valid_q && !we_q, pix_q == 8'd0,
                    "transparent pixel carries a nonzero value")
  `CKRB_ASSERT_NEXT(a_accept_fills, clk_i, rst_ni, in_accept, s1_valid_q,
                    "accepted beat not held in input register")
  `CKRB_ASSERT_NEXT(a_s1_holds, clk_i, rst_ni, s1_valid_q && !out_ready, s1_valid_q,
                    "input register dropped a beat while blocked")

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for color_keyed_rect_blit_core
// Streams source pixels through the blitter under several register settings,
// predicts every frame-buffer write in step with the input beats and checks
// each output beat against the oldest prediction, with random gaps on both
// channels, a long output hold-off and a full drain pause.
// ----------------------------------------------------------------------------
module tb;

  // Blit mode codes. Bit 1 selects the color add, any nonzero mode keys zero.
  localparam logic [1:0] MODE_OPAQUE        = 2'd0;
  localparam logic [1:0] MODE_KEY           = 2'd1;
  localparam logic [1:0] MODE_KEY_ADD       = 2'd2;
  localparam logic [1:0] MODE_KEY_ADD_ALIAS = 2'd3;

  localparam int unsigned PIPE_LATENCY  = 2;
  localparam int unsigned LONG_HOLD     = 200;
  localparam int unsigned IDLE_LIMIT    = 5000;
  localparam int unsigned RANDOM_PIXELS = 700;

  typedef struct packed {
    logic [15:0] addr;
    logic [7:0]  pixel;
    logic        wr_en;
    logic        last;
  } fb_write_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                             in_valid = 1'b0;
  logic                             in_stall_o;
  logic [7:0]                       src_pixel = '0;
  logic                             out_valid_o;
  logic                             out_stall = 1'b0;
  logic [15:0]                      dest_address_o;
  logic [7:0]                       pixel_out_o;
  logic                             write_enable_o;
  logic                             last_pixel_o;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready_o;
  logic [ckrb_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [ckrb_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  color_keyed_rect_blit_core dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .src_pixel_i    (src_pixel),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .dest_address_o (dest_address_o),
    .pixel_out_o    (pixel_out_o),
    .write_enable_o (write_enable_o),
    .last_pixel_o   (last_pixel_o),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the registers and of the rectangle walk.
  logic [15:0] fb_start  = ckrb_pkg::DEST_START_RST;
  logic [8:0]  rect_w    = ckrb_pkg::RECT_WIDTH_RST;
  logic [7:0]  rect_h    = ckrb_pkg::RECT_HEIGHT_RST;
  logic [1:0]  mode      = ckrb_pkg::BLIT_MODE_RST;
  logic [7:0]  tint      = ckrb_pkg::COLOR_ADD_RST;
  logic [8:0]  col       = '0;
  logic [7:0]  row       = '0;
  logic [15:0] row_base  = '0;

  logic [7:0] src_backlog[$];   // pixels waiting for the driver
  fb_write_t  writes_due[$];    // predicted writes in output order

  int unsigned in_idle_pct  = 0;
  int unsigned out_idle_pct = 0;
  int unsigned hold_reqs    = 0;
  int unsigned mismatches   = 0;
  int unsigned idle_cycles  = 0;
  bit          in_taken     = 1'b0;
  bit          out_taken    = 1'b0;
  bit          cfg_taken    = 1'b0;

  // A gap of zero most of the time at low idle rates; when a gap happens it
  // is usually short, and now and then a long one.
  function automatic int unsigned pick_gap(input int unsigned pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(40, 12);
    return $urandom_range(3, 1);
  endfunction

  // Zero is the key color, so it is drawn often; 0xFF exercises the add wrap.
  function automatic logic [7:0] pick_pixel();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 25) return 8'h00;
    if (r < 35) return 8'hFF;
    return 8'($urandom);
  endfunction

  function automatic void restart_walk();
    col      = '0;
    row      = '0;
    row_base = fb_start;
  endfunction

  // Works out the write for one source pixel and advances the walk.
  function automatic fb_write_t predict_fb_write(input logic [7:0] src);
    fb_write_t  wr;
    logic [8:0] w_lim;
    logic [7:0] h_lim;
    logic       keyed;
    logic       end_row;
    logic       end_rect;
    // A zero width or height behaves as one.
    w_lim    = (rect_w == '0) ? 9'd1 : rect_w;
    h_lim    = (rect_h == '0) ? 8'd1 : rect_h;
    keyed    = (mode != MODE_OPAQUE);
    wr.addr  = row_base + 16'(col);
    wr.wr_en = !(keyed && src == 8'h00);
    // A transparent pixel reports zero as its value.
    if (!wr.wr_en) wr.pixel = 8'h00;
    else if (mode[1]) wr.pixel = src + tint;
    else wr.pixel = src;
    end_row  = (col >= w_lim - 9'd1);
    end_rect = end_row && (row >= h_lim - 8'd1);
    wr.last  = end_rect;
    if (end_rect) begin
      restart_walk();
    end else if (end_row) begin
      col      = '0;
      row      = row + 8'd1;
      row_base = row_base + ckrb_pkg::SCREEN_WIDTH;
    end else begin
      col = col + 9'd1;
    end
    return wr;
  endfunction

  task automatic note_mismatch(input string what, input fb_write_t exp_wr,
                               input fb_write_t got_wr);
    mismatches++;
    if (mismatches <= 10) begin
      $display("MISMATCH %s: expected addr=%h pixel=%h we=%b last=%b,",
               what, exp_wr.addr, exp_wr.pixel, exp_wr.wr_en, exp_wr.last,
               " got addr=%h pixel=%h we=%b last=%b",
               got_wr.addr, got_wr.pixel, got_wr.wr_en, got_wr.last);
    end
  endtask

  // Monitor: everything is sampled at the rising edge. Input beats feed the
  // predictor, output beats are checked against the oldest prediction.
  always @(posedge clk) begin
    fb_write_t got_wr;
    fb_write_t exp_wr;
    in_taken  = in_valid && !in_stall_o;
    out_taken = out_valid_o && !out_stall;
    cfg_taken = cfg_valid && cfg_ready_o;
    if (in_taken) writes_due.push_back(predict_fb_write(src_pixel));
    if (out_taken) begin
      got_wr = '{dest_address_o, pixel_out_o, write_enable_o, last_pixel_o};
      if (writes_due.size() == 0) begin
        note_mismatch("write beat with nothing expected", 'x, got_wr);
      end else begin
        exp_wr = writes_due.pop_front();
        if (got_wr.addr !== exp_wr.addr) note_mismatch("dest_address", exp_wr, got_wr);
        else if (got_wr.pixel !== exp_wr.pixel) note_mismatch("pixel_out", exp_wr, got_wr);
        else if (got_wr.wr_en !== exp_wr.wr_en) note_mismatch("write_enable", exp_wr, got_wr);
        else if (got_wr.last !== exp_wr.last) note_mismatch("last_pixel", exp_wr, got_wr);
      end
    end
  end

  // Watchdog: too long without any beat on any channel means a hang.
  always @(posedge clk) begin
    if (in_taken || out_taken || cfg_taken) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("color_keyed_rect_blit_core test failed");
      $finish;
    end
  end

  // Pixel driver: a new beat is offered only after the previous one was
  // taken, so a stalled beat holds its payload. Valid never looks at stall.
  int unsigned in_gap_left = 0;
  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (in_gap_left != 0) begin
        in_valid <= 1'b0;
        in_gap_left--;
      end else if (src_backlog.size() != 0) begin
        in_valid    <= 1'b1;
        src_pixel   <= src_backlog.pop_front();
        in_gap_left = pick_gap(in_idle_pct);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Write receiver: random stall bursts, plus a long hold-off each time the
  // stimulus asks for one. The hold length is counted here.
  int unsigned holds_done = 0;
  int unsigned stall_left = 0;
  always @(negedge clk) begin
    if (holds_done != hold_reqs) begin
      holds_done++;
      stall_left = LONG_HOLD;
    end
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      stall_left = pick_gap(out_idle_pct);
    end
  end

  // One register write; the shadow copy follows once the beat is taken.
  task automatic cfg_write(input logic [ckrb_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [ckrb_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready_o);
    case (idx)
      ckrb_pkg::CFG_DEST_START: begin
        fb_start = data;
        restart_walk();
      end
      ckrb_pkg::CFG_RECT_WIDTH: begin
        rect_w = data[8:0];
        restart_walk();
      end
      ckrb_pkg::CFG_RECT_HEIGHT: begin
        rect_h = data[7:0];
        restart_walk();
      end
      ckrb_pkg::CFG_BLIT_MODE: mode = data[1:0];
      ckrb_pkg::CFG_COLOR_ADD: tint = data[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random bits above a register's width, which the block must drop.
  function automatic logic [ckrb_pkg::CFG_DATA_W-1:0] with_junk(input int unsigned value,
                                                                input int unsigned bits);
    logic [ckrb_pkg::CFG_DATA_W-1:0] junk;
    junk = 16'($urandom) & ~((16'd1 << bits) - 16'd1);
    return junk | 16'(value);
  endfunction

  task automatic queue_pixels(input int unsigned n, inout int unsigned sent);
    repeat (n) src_backlog.push_back(pick_pixel());
    sent += n;
  endtask

  // Waits until every queued pixel went in and every write came out.
  task automatic wait_drained();
    do @(posedge clk); while (src_backlog.size() != 0 || in_valid || writes_due.size() != 0);
    repeat (PIPE_LATENCY) @(posedge clk);
  endtask

  initial begin
    int unsigned sent;
    int unsigned phase_no;
    int unsigned n;
    int unsigned w_eff;
    int unsigned h_eff;
    sent     = 0;
    phase_no = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. Registers at their reset values: a 1x1 opaque rectangle,
    // so both pixels are last and pixel zero is still written.
    src_backlog = '{8'h00, 8'hFF};
    wait_drained();

    // 3x2 keyed rectangle whose first row wraps past the top of the address
    // space; the add value must be ignored in this mode.
    cfg_write(ckrb_pkg::CFG_DEST_START, 16'hFFFE);
    cfg_write(ckrb_pkg::CFG_RECT_WIDTH, 16'd3);
    cfg_write(ckrb_pkg::CFG_RECT_HEIGHT, 16'd2);
    cfg_write(ckrb_pkg::CFG_BLIT_MODE, 16'(MODE_KEY));
    cfg_write(ckrb_pkg::CFG_COLOR_ADD, 16'h00FF);
    src_backlog = '{8'h00, 8'h01, 8'h80, 8'hFF, 8'h00, 8'h55};
    wait_drained();

    // Key plus add with a wrapping sum.
    cfg_write(ckrb_pkg::CFG_BLIT_MODE, 16'(MODE_KEY_ADD));
    cfg_write(ckrb_pkg::CFG_COLOR_ADD, 16'h0001);
    src_backlog = '{8'h00, 8'hFF, 8'h7F};
    wait_drained();

    // Mode three acts like key plus add. Changing the mode and the add value
    // does not restart the walk.
    cfg_write(ckrb_pkg::CFG_BLIT_MODE, 16'(MODE_KEY_ADD_ALIAS));
    cfg_write(ckrb_pkg::CFG_COLOR_ADD, 16'h0080);
    src_backlog = '{8'h00, 8'h80, 8'h01};
    wait_drained();
    cfg_write(ckrb_pkg::CFG_BLIT_MODE, 16'(MODE_OPAQUE));
    src_backlog = '{8'h00, 8'h00, 8'h33};
    wait_drained();

    // Zero width and height act as one; the junk in the upper data bits
    // must be masked off, leaving zero.
    cfg_write(ckrb_pkg::CFG_RECT_WIDTH, 16'hFE00);
    cfg_write(ckrb_pkg::CFG_RECT_HEIGHT, 16'hFF00);
    src_backlog = '{8'h42, 8'h00};
    wait_drained();

    // Widest possible row, far beyond the screen, starting near the top of
    // the address space. Writes to unused indexes must change nothing and
    // must not restart the row.
    cfg_write(ckrb_pkg::CFG_RECT_WIDTH, 16'hFFFF);
    cfg_write(ckrb_pkg::CFG_RECT_HEIGHT, 16'h0001);
    cfg_write(ckrb_pkg::CFG_DEST_START, 16'hFF00);
    src_backlog = '{8'h10, 8'h20};
    wait_drained();
    for (int i = int'(ckrb_pkg::CFG_COLOR_ADD) + 1; i < (1 << ckrb_pkg::CFG_INDEX_W); i++) begin
      cfg_write(ckrb_pkg::cfg_idx_e'(i), 16'($urandom));
    end
    src_backlog = '{8'h30};
    wait_drained();

    // Random part, phase by phase. Each phase may rewrite any register, then
    // streams whole rectangles and usually a partial one, so that the next
    // phase may change the mode in mid-rectangle.
    while (sent < RANDOM_PIXELS) begin
      if (phase_no == 0) begin
        // Back-to-back beats with no idling on either side.
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end else begin
        in_idle_pct  = ($urandom_range(2) == 0) ? 0 : $urandom_range(70, 10);
        out_idle_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(70, 10);
      end

      if (phase_no == 5) begin
        // Tallest rectangle (255 rows) or one of 200 rows, one pixel wide.
        cfg_write(ckrb_pkg::CFG_RECT_WIDTH, with_junk(1, 9));
        cfg_write(ckrb_pkg::CFG_RECT_HEIGHT,
                  with_junk(($urandom_range(3) == 0) ? 255 : 200, 8));
        cfg_write(ckrb_pkg::CFG_DEST_START, 16'($urandom));
      end else if (phase_no == 9) begin
        // A full screen row, or the widest row the register holds.
        cfg_write(ckrb_pkg::CFG_RECT_WIDTH,
                  with_junk(($urandom_range(3) == 0) ? 511 : 320, 9));
        cfg_write(ckrb_pkg::CFG_RECT_HEIGHT, with_junk(1, 8));
        cfg_write(ckrb_pkg::CFG_DEST_START,
                  ($urandom_range(1) == 0) ? 16'hFFFF : 16'h0000);
      end else if ($urandom_range(9) < 7) begin
        if ($urandom_range(9) < 6) begin
          cfg_write(ckrb_pkg::CFG_DEST_START, ($urandom_range(4) == 0) ?
                    16'($urandom_range(16'hFFFF, 16'hFF00)) : 16'($urandom));
        end
        if ($urandom_range(9) < 6) begin
          cfg_write(ckrb_pkg::CFG_RECT_WIDTH,
                    with_junk(($urandom_range(9) == 0) ? 0 : $urandom_range(8, 1), 9));
        end
        if ($urandom_range(9) < 6) begin
          cfg_write(ckrb_pkg::CFG_RECT_HEIGHT,
                    with_junk(($urandom_range(9) == 0) ? 0 : $urandom_range(5, 1), 8));
        end
      end
      if ($urandom_range(9) < 7) cfg_write(ckrb_pkg::CFG_BLIT_MODE, 16'($urandom));
      if ($urandom_range(9) < 6) cfg_write(ckrb_pkg::CFG_COLOR_ADD, 16'($urandom));

      w_eff = (rect_w == '0) ? 1 : rect_w;
      h_eff = (rect_h == '0) ? 1 : rect_h;
      if (phase_no == 5 || phase_no == 9) begin
        n = w_eff * h_eff + $urandom_range(3);
      end else begin
        n = w_eff * h_eff * $urandom_range(2, 1) + $urandom_range(w_eff);
        if (n > 60) n = $urandom_range(60, 20);
      end

      if (phase_no == 2 || (phase_no > 10 && $urandom_range(9) == 0)) begin
        // Output held off for a long stretch while pixels keep coming, so
        // the block fills and stalls its input.
        hold_reqs++;
        queue_pixels(n + 30, sent);
      end else if (phase_no == 4 || (phase_no > 10 && $urandom_range(9) == 0)) begin
        // Sender stops until every write has come out, then resumes.
        queue_pixels(n / 2, sent);
        wait_drained();
        queue_pixels(n - n / 2, sent);
      end else begin
        queue_pixels(n, sent);
      end
      wait_drained();
      phase_no++;
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && writes_due.size() == 0) begin
      $display("color_keyed_rect_blit_core test passed");
    end else begin
      $display("color_keyed_rect_blit_core test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/ckrb_pkg.sv
rtl/ckrb_cfg_regs.sv
rtl/ckrb_addr_gen.sv
rtl/ckrb_pixel_pipe.sv
rtl/color_keyed_rect_blit_core.sv
tb/tb.sv
